[rtl/whta_pkg.sv]
// ----------------------------------------------------------------------------
// whta_pkg
// Shared types and constants of the windowed heading turn average block.
// ----------------------------------------------------------------------------
package whta_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 1024;
	localparam logic [31:0] WINDOW_RESET    = 32'd10000;
	localparam int unsigned QUEUE_DEPTH     = 4;

	localparam int unsigned HDG_W           = 16;
	localparam int unsigned STAMP_W         = 32;
	localparam int unsigned AVG_W           = 16;
	localparam int unsigned USED_W          = 11;
	localparam logic [HDG_W-1:0] FULL_CIRCLE = 16'd36000;

	typedef enum logic [1:0] {
		KIND_FIRST = 2'd0,
		KIND_DELTA = 2'd1,
		KIND_SKIP  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [HDG_W-1:0] heading;
		logic             last;
	} entry_t;

endpackage

[rtl/whta_front.sv]
// ----------------------------------------------------------------------------
// whta_front
// Accepts history entries, folds the heading and sorts each entry against the
// time window of its history.
// ----------------------------------------------------------------------------
module whta_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      window_ms_wr_en,
	input  logic [31:0]               window_ms_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [15:0]               in_heading,
	input  logic [31:0]               in_stamp,
	input  logic                      in_last,
	output logic                      push_valid,
	input  logic                      push_ready,
	output whta_pkg::entry_t          push_entry
);
	import whta_pkg::*;

	logic [31:0]      window_q;
	logic             started_q;
	logic             closed_q;
	logic [31:0]      newest_q;
	logic [HDG_W-1:0] hdg;
	logic signed [33:0] age;
	logic             over;
	logic             take;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign take       = in_valid & push_ready;

	assign hdg  = (in_heading >= FULL_CIRCLE) ? in_heading - FULL_CIRCLE : in_heading;
	assign age  = $signed({2'b00, newest_q}) - $signed({2'b00, in_stamp});
	assign over = age > $signed({2'b00, window_q});

	always_comb begin
		push_entry.heading = hdg;
		push_entry.last    = in_last;
		if (!started_q) begin
			push_entry.kind = KIND_FIRST;
		end else if (!closed_q && !over) begin
			push_entry.kind = KIND_DELTA;
		end else begin
			push_entry.kind = KIND_SKIP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RESET;
			started_q <= 1'b0;
			closed_q  <= 1'b0;
			newest_q  <= '0;
		end else begin
			if (window_ms_wr_en) begin
				window_q <= window_ms_wr_data;
			end
			if (take) begin
				if (in_last) begin
					started_q <= 1'b0;
					closed_q  <= 1'b0;
				end else if (!started_q) begin
					started_q <= 1'b1;
					newest_q  <= in_stamp;
				end else if (over) begin
					closed_q <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/whta_queue.sv]
// ----------------------------------------------------------------------------
// whta_queue
// Short queue of sorted entries between the front and the back.
// ----------------------------------------------------------------------------
module whta_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  whta_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output whta_pkg::entry_t pop_entry
);
	import whta_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = fill_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[rtl/whta_back.sv]
// ----------------------------------------------------------------------------
// whta_back
// Accumulates wrapped heading deltas, divides sum by count bit-serially and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module whta_back #(
	parameter int unsigned MAX_SAMPLES = whta_pkg::MAX_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  whta_pkg::entry_t              pop_entry,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [whta_pkg::AVG_W-1:0] out_avg,
	output logic [whta_pkg::USED_W-1:0]   out_used,
	output logic                          out_status
);
	import whta_pkg::*;

	localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SUM_W  = CNT_W + 16;
	localparam int unsigned STEP_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		ST_ACC  = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                  state_q;
	logic [HDG_W-1:0]        prev_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SUM_W-1:0]        mag_q;
	logic [CNT_W-1:0]        rem_q;
	logic [CNT_W-1:0]        dvsr_q;
	logic                    neg_q;
	logic [STEP_W-1:0]       step_q;
	logic                    out_valid_q;
	logic signed [AVG_W-1:0] out_avg_q;
	logic [USED_W-1:0]       out_used_q;
	logic                    out_status_q;

	logic                    pop;
	logic signed [16:0]      diff;
	logic signed [16:0]      turn;
	logic signed [SUM_W-1:0] sum_n;
	logic [CNT_W-1:0]        cnt_n;
	logic [HDG_W-1:0]        prev_n;
	logic [CNT_W:0]          rem_sh;
	logic                    qbit;
	logic [AVG_W-1:0]        quo;
	logic                    out_free;

	assign pop_ready = state_q == ST_ACC;
	assign pop       = pop_valid & pop_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign diff = $signed({1'b0, prev_q}) - $signed({1'b0, pop_entry.heading});

	always_comb begin
		if (diff >= 17'sd18000) begin
			turn = diff - 17'sd36000;
		end else if (diff < -17'sd18000) begin
			turn = diff + 17'sd36000;
		end else begin
			turn = diff;
		end
	end

	always_comb begin
		sum_n  = sum_q;
		cnt_n  = cnt_q;
		prev_n = prev_q;
		case (pop_entry.kind)
			KIND_FIRST: begin
				prev_n = pop_entry.heading;
			end
			KIND_DELTA: begin
				if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
					sum_n  = sum_q + {{(SUM_W-17){turn[16]}}, turn};
					cnt_n  = cnt_q + 1'b1;
					prev_n = pop_entry.heading;
				end
			end
			default: begin
			end
		endcase
	end

	assign rem_sh = {rem_q, mag_q[SUM_W-1]};
	assign qbit   = rem_sh >= {1'b0, dvsr_q};
	assign quo    = neg_q ? AVG_W'(-mag_q) : mag_q[AVG_W-1:0];

	always_ff @(posedge clk) begin
		case (state_q)
			ST_ACC: begin
				if (pop && pop_entry.last) begin
					mag_q  <= sum_n[SUM_W-1] ? -sum_n : sum_n;
					neg_q  <= sum_n[SUM_W-1];
					dvsr_q <= cnt_n;
					rem_q  <= '0;
				end
			end
			ST_DIV: begin
				mag_q <= {mag_q[SUM_W-2:0], qbit};
				rem_q <= qbit ? CNT_W'(rem_sh - {1'b0, dvsr_q}) : rem_sh[CNT_W-1:0];
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_avg_q    <= quo;
			out_used_q   <= USED_W'(dvsr_q);
			out_status_q <= dvsr_q == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			prev_q      <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACC: begin
					if (pop) begin
						if (pop_entry.last) begin
							prev_q  <= '0;
							sum_q   <= '0;
							cnt_q   <= '0;
							step_q  <= '0;
							state_q <= (cnt_n == '0) ? ST_DONE : ST_DIV;
						end else begin
							prev_q <= prev_n;
							sum_q  <= sum_n;
							cnt_q  <= cnt_n;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_avg    = out_avg_q;
	assign out_used   = out_used_q;
	assign out_status = out_status_q;

endmodule

[rtl/windowed_heading_turn_average.sv]
// ----------------------------------------------------------------------------
// windowed_heading_turn_average
// Average signed heading change over the entries of a heading history that
// lie within a time window of its newest entry.
//
// channel    dir  fields (low bit up)                        accepted when
// s_axis     in   tdata: heading_cdeg[15:0] stamp_ms[47:16]   tvalid & tready
//                 tlast: last_entry
// m_axis     out  tdata: avg_turn_cdeg[15:0] used_count[26:16] tvalid & tready
//                 tuser: status
// window_ms  in   window_ms_wr_data                          window_ms_wr_en
//
// Entries are taken one per cycle while the back accumulates. A last entry
// with a nonzero count passes through the bit-serial divider, one quotient bit
// per cycle; with no count it skips the divider.
// The queue keeps taking entries meanwhile until it is full.
// Reset clears all history state and sets window_ms to 10000.
// A stalled m_axis holds its result; the back waits only for a second one.
// ----------------------------------------------------------------------------
module windowed_heading_turn_average #(
	parameter int unsigned MAX_SAMPLES = whta_pkg::MAX_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        window_ms_wr_en,
	input  logic [31:0] window_ms_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // heading_cdeg, stamp_ms
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // avg_turn_cdeg, used_count, zero fill
	output logic        m_axis_tuser    // status
);
	import whta_pkg::*;

	logic                    push_valid;
	logic                    push_ready;
	entry_t                  push_entry;
	logic                    pop_valid;
	logic                    pop_ready;
	entry_t                  pop_entry;
	logic signed [AVG_W-1:0] avg;
	logic [USED_W-1:0]       used;

	whta_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.window_ms_wr_en   (window_ms_wr_en),
		.window_ms_wr_data (window_ms_wr_data),
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.in_heading        (s_axis_tdata[15:0]),
		.in_stamp          (s_axis_tdata[47:16]),
		.in_last           (s_axis_tlast),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_entry        (push_entry)
	);

	whta_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	whta_back #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_avg    (avg),
		.out_used   (used),
		.out_status (m_axis_tuser)
	);

	assign m_axis_tdata = {5'b0, used, avg};

endmodule

[rtl/whta_checker.sv]
// ----------------------------------------------------------------------------
// whta_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module whta_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result request dropped while stalled");

	a_empty_avg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
		else $error("empty window with nonzero average");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[26:16] == 11'd0)
		else $error("empty window with nonzero count");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:27] == 5'd0)
		else $error("result fill bits not zero");

endmodule

bind windowed_heading_turn_average whta_checker u_whta_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for windowed_heading_turn_average. Heading histories are
// streamed in on s_axis while an in-bench predictor tracks the history state
// and queues the expected average for each last entry; every m_axis request
// is compared field by field against the oldest queued average. Directed
// cases and window extremes run without idling; random histories run under
// several sender and receiver idle ratios.
// ----------------------------------------------------------------------------
module testbench;

	import whta_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam logic [31:0] WINDOW_MAX     = 32'hFFFF_FFFF;

	typedef struct {
		logic signed [AVG_W-1:0] avg;
		logic [USED_W-1:0]       used;
		logic                    status;
	} turn_avg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        window_ms_wr_en = 1'b0;
	logic [31:0] window_ms_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // heading_cdeg, stamp_ms
	logic        s_axis_tlast = 1'b0; // last_entry
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // avg_turn_cdeg, used_count, zero fill
	logic        m_axis_tuser;        // status

	// predictor state
	logic [31:0]       window_cfg = WINDOW_RESET;
	logic              hist_open = 1'b0;
	logic              beyond_window = 1'b0;
	logic [HDG_W-1:0]  last_heading = '0;
	logic [31:0]       ref_stamp = '0;
	longint            turn_sum = 0;
	int unsigned       turn_count = 0;

	turn_avg_t   expected_turns[$];
	int unsigned error_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles = 0;

	windowed_heading_turn_average uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.window_ms_wr_en   (window_ms_wr_en),
		.window_ms_wr_data (window_ms_wr_data),
		.s_axis_tvalid     (s_axis_tvalid),
		.s_axis_tready     (s_axis_tready),
		.s_axis_tdata      (s_axis_tdata),
		.s_axis_tlast      (s_axis_tlast),
		.m_axis_tvalid     (m_axis_tvalid),
		.m_axis_tready     (m_axis_tready),
		.m_axis_tdata      (m_axis_tdata),
		.m_axis_tuser      (m_axis_tuser)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic predict_entry(input logic [HDG_W-1:0] raw_hdg, input logic [31:0] stamp,
			input logic last);
		logic [HDG_W-1:0] hdg;
		longint           age;
		int               turn;
		turn_avg_t        res;
		hdg = raw_hdg % FULL_CIRCLE;
		if (!hist_open) begin
			hist_open    = 1'b1;
			ref_stamp    = stamp;
			last_heading = hdg;
		end else if (!beyond_window) begin
			age = $signed({32'd0, ref_stamp}) - $signed({32'd0, stamp});
			if (age > $signed({32'd0, window_cfg})) begin
				beyond_window = 1'b1;
			end else if (turn_count < MAX_SAMPLES_DEF) begin
				turn = int'(last_heading) - int'(hdg);
				if (turn >= 18000)
					turn -= 36000;
				else if (turn < -18000)
					turn += 36000;
				turn_sum += turn;
				last_heading = hdg;
				turn_count++;
			end
		end
		if (last) begin
			res.avg    = (turn_count != 0) ? AVG_W'(turn_sum / longint'(turn_count)) : '0;
			res.used   = USED_W'(turn_count);
			res.status = (turn_count == 0);
			expected_turns.push_back(res);
			hist_open     = 1'b0;
			beyond_window = 1'b0;
			last_heading  = '0;
			ref_stamp     = '0;
			turn_sum      = 0;
			turn_count    = 0;
		end
	endtask

	task automatic send_entry(input logic [HDG_W-1:0] hdg, input logic [31:0] stamp,
			input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {stamp, hdg};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_entry(hdg, stamp, last);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_turns.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [31:0] value);
		wait_idle();
		window_ms_wr_en   <= 1'b1;
		window_ms_wr_data <= value;
		@(posedge clk);
		window_ms_wr_en <= 1'b0;
		window_cfg = value;
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic send_random_history(input int unsigned len);
		logic [31:0]      ref_t;
		logic [31:0]      stamp;
		logic [HDG_W-1:0] hdg;
		int unsigned      pick;
		ref_t = $urandom;
		for (int unsigned i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (i == 0)
				stamp = ref_t;
			else if (pick < 70)
				stamp = ref_t - $urandom_range(window_cfg, 0);
			else if (pick < 78)
				stamp = ref_t + $urandom_range(5000, 1);
			else if (pick < 84)
				stamp = ref_t - window_cfg;
			else if (pick < 94)
				stamp = ref_t - window_cfg - 1 - $urandom_range(1000, 0);
			else
				stamp = $urandom;
			if ($urandom_range(99) < 85)
				hdg = $urandom_range(35999, 0);
			else
				hdg = $urandom_range(16'hFFFF, 0);
			send_entry(hdg, stamp, i == len - 1);
		end
	endtask

	// window 10000 from reset
	task automatic test_directed_cases();
		send_entry(16'd100, 32'd5000, 1'b1);       // lone entry
		send_entry(16'd0, 32'd20000, 1'b0);
		send_entry(16'd35999, 32'd19000, 1'b0);    // wrap through north
		send_entry(16'hFFFF, 32'd21000, 1'b0);     // out of range, newer stamp
		send_entry(16'd36000, 32'd12000, 1'b0);    // reduces to zero
		send_entry(16'd18000, 32'd10000, 1'b0);    // age equals window, half turn
		send_entry(16'd0, 32'd10000, 1'b0);
		send_entry(16'd4000, 32'd9999, 1'b0);      // closes window
		send_entry(16'd9000, 32'd15000, 1'b1);     // ignored after close
		send_entry(16'd1000, 32'd5000, 1'b0);
		send_entry(16'd1100, 32'd4000, 1'b0);
		send_entry(16'd1150, 32'd3000, 1'b0);
		send_entry(16'd1151, 32'd2000, 1'b1);      // negative, truncated
		send_entry(16'd1151, 32'd0, 1'b0);
		send_entry(16'd1000, 32'hFFFF_FFFF, 1'b0); // far newer stamp
		send_entry(16'd1001, 32'hFFFF_FFF0, 1'b1);
		send_entry(16'd300, 32'hFFFF_FFFF, 1'b0);
		send_entry(16'd200, 32'hFFFF_0000, 1'b1);  // last entry beyond window
		send_entry(16'd35999, 32'd50000, 1'b0);
		send_entry(16'd0, 32'd49000, 1'b1);
	endtask

	task automatic test_window_extremes();
		set_window(32'd0);
		send_entry(16'd500, 32'd7000, 1'b0);
		send_entry(16'd700, 32'd7000, 1'b0);
		send_entry(16'd800, 32'd7001, 1'b0);
		send_entry(16'd900, 32'd6999, 1'b0);
		send_entry(16'd100, 32'd7000, 1'b1);
		set_window(WINDOW_MAX);
		send_entry(16'd20000, 32'hFFFF_FFFF, 1'b0);
		send_entry(16'd100, 32'd0, 1'b0);
		send_entry(16'd35000, 32'h8000_0000, 1'b0);
		send_entry(16'd17000, 32'd1, 1'b1);
	endtask

	task automatic test_random_histories();
		int unsigned sent;
		int unsigned len;
		for (int unsigned phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					set_window($urandom_range(50000, 1));
					set_idling(0, 0);
				end
				1: begin
					set_window(32'd0);
					set_idling(55, 0);
				end
				2: begin
					set_window(WINDOW_MAX);
					set_idling(0, 55);
				end
				default: begin
					set_window(WINDOW_RESET);
					set_idling(17, 17);
				end
			endcase
			sent = 0;
			while (sent < 90) begin
				len = ($urandom_range(99) < 80) ? $urandom_range(12, 1) : $urandom_range(40, 13);
				send_random_history(len);
				sent += len;
			end
		end
	endtask

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		turn_avg_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_turns.size() == 0) begin
				report_mismatch("result with no history pending");
			end else begin
				want = expected_turns[0];
				expected_turns.delete(0);
				if (m_axis_tdata[15:0] !== want.avg)
					report_mismatch($sformatf("avg_turn_cdeg %0d, want %0d",
						$signed(m_axis_tdata[15:0]), want.avg));
				if (m_axis_tdata[26:16] !== want.used)
					report_mismatch($sformatf("used_count %0d, want %0d",
						m_axis_tdata[26:16], want.used));
				if (m_axis_tuser !== want.status)
					report_mismatch($sformatf("status %0b, want %0b",
						m_axis_tuser, want.status));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_window_extremes();
		test_random_histories();
		wait_idle();
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[windowed_heading_turn_average.f]
rtl/whta_pkg.sv
rtl/whta_front.sv
rtl/whta_queue.sv
rtl/whta_back.sv
rtl/windowed_heading_turn_average.sv
rtl/whta_checker.sv
sim/testbench.sv
